### sv/wbss_pkg.sv
// Package for the weighted byte signature scanner.
// Holds the signature table, weights, widths, register indexes and shared types.
// No dependencies.
package wbss_pkg;

   localparam int NUM_SIGS = 4;
   localparam int MAX_PAT  = 8;
   localparam int WIN_LEN  = MAX_PAT - 1;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int SCORE_W  = 7;
   localparam int WEIGHT_W = 4;
   localparam int SUM_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_LIMIT = 1'd1;

   localparam logic [COUNT_W-1:0] MIN_LENGTH_RESET  = 8'd8;
   localparam logic [SCORE_W-1:0] SCORE_LIMIT_RESET = 7'd100;

   localparam logic [COUNT_W-1:0] SIG_LEN [NUM_SIGS] = '{8'd8, 8'd2, 8'd2, 8'd5};
   localparam logic [WEIGHT_W-1:0] SIG_WEIGHT [NUM_SIGS] = '{4'd8, 4'd7, 4'd5, 4'd6};

   // pattern bytes, last byte of the pattern first
   localparam logic [BYTE_W-1:0] SIG_TAIL [NUM_SIGS][MAX_PAT] = '{
      '{8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90},
      '{8'h80, 8'hCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h61, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h76, 8'h89, 8'h5E, 8'h1F, 8'hEB, 8'h00, 8'h00, 8'h00}
   };

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [NUM_SIGS-1:0] found;
   } scan_status_type;

endpackage

### sv/wbss_match.sv
// Byte window, saturating byte count and per-signature found flags.
// Compares the incoming byte plus the window against every signature.
// Depends on wbss_pkg.
module wbss_match
   import wbss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [BYTE_W-1:0]   data_byte,
   input  logic                last_byte,
   output scan_status_type     status
);

   logic [BYTE_W-1:0]   recent_ff [WIN_LEN];
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic [NUM_SIGS-1:0] found_ff;
   logic [NUM_SIGS-1:0] found_in;
   logic [BYTE_W-1:0]   window [MAX_PAT];
   logic [NUM_SIGS-1:0] hit;

   assign count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

   always_comb begin
      window[0] = data_byte;
      for (int k = 1; k < MAX_PAT; k++) begin
         window[k] = recent_ff[k-1];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SIGS; i++) begin
         hit[i] = (count_in >= SIG_LEN[i]);
         for (int k = 0; k < MAX_PAT; k++) begin
            if ((COUNT_W'(k) < SIG_LEN[i]) && (window[k] != SIG_TAIL[i][k])) begin
               hit[i] = 1'b0;
            end
         end
      end
   end

   assign found_in     = found_ff | hit;
   assign status.count = count_in;
   assign status.found = found_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= '0;
         for (int k = 0; k < WIN_LEN; k++) begin
            recent_ff[k] <= '0;
         end
      end else if (accept) begin
         if (last_byte) begin
            count_ff <= '0;
            found_ff <= '0;
            for (int k = 0; k < WIN_LEN; k++) begin
               recent_ff[k] <= '0;
            end
         end else begin
            count_ff <= count_in;
            found_ff <= found_in;
            recent_ff[0] <= data_byte;
            for (int k = 1; k < WIN_LEN; k++) begin
               recent_ff[k] <= recent_ff[k-1];
            end
         end
      end
   end

endmodule

### sv/wbss_score.sv
// Weighted score of the found signatures, saturated and gated by buffer length.
// Depends on wbss_pkg.
module wbss_score
   import wbss_pkg::*;
(
   input  scan_status_type     status,
   input  logic [COUNT_W-1:0]  min_length,
   input  logic [SCORE_W-1:0]  score_limit,
   output logic [SCORE_W-1:0]  score
);

   logic [SUM_W-1:0] sum;

   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_SIGS; i++) begin
         if (status.found[i]) begin
            sum = sum + SUM_W'(SIG_WEIGHT[i]);
         end
      end
   end

   always_comb begin
      if (status.count < min_length) begin
         score = '0;
      end else if (sum > SUM_W'(score_limit)) begin
         score = score_limit;
      end else begin
         score = sum[SCORE_W-1:0];
      end
   end

endmodule

### sv/wbss_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on wbss_pkg.
module wbss_out_buf
   import wbss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [SCORE_W-1:0]  push_score,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SCORE_W-1:0]  rsp_threat_score
);

   logic               main_valid_ff;
   logic [SCORE_W-1:0] main_data_ff;
   logic               skid_valid_ff;
   logic [SCORE_W-1:0] skid_data_ff;
   logic               pop;

   assign pop              = main_valid_ff && !rsp_stall;
   assign full             = skid_valid_ff;
   assign rsp_valid        = main_valid_ff;
   assign rsp_threat_score = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !main_valid_ff) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : push_score;
      end else if (push) begin
         skid_data_ff <= push_score;
      end
   end

endmodule

### sv/weighted_byte_signature_scanner_top.sv
// Weighted byte signature scanner, top level.
// Depends on wbss_pkg, wbss_match, wbss_score and wbss_out_buf.
//
// Accepts one byte per clock cycle while req_stall is low. A transfer with req_last_byte
// set yields one threat score on the rsp_ channel, in the following cycle when the output
// register is free; other bytes yield none.
// Signature compare, scoring and saturation all complete in the cycle a byte is
// accepted; the score lands in a two-entry output buffer, and req_stall rises only
// while both entries hold scores that the downstream side has not taken.
module weighted_byte_signature_scanner_top
   import wbss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SCORE_W-1:0]     rsp_threat_score,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [COUNT_W-1:0] min_length_ff;
   logic [SCORE_W-1:0] score_limit_ff;
   logic               accept;
   logic               full;
   scan_status_type    status;
   logic [SCORE_W-1:0] score;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff  <= MIN_LENGTH_RESET;
         score_limit_ff <= SCORE_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_LENGTH:  min_length_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_SCORE_LIMIT: score_limit_ff <= csr_wdata[SCORE_W-1:0];
            default: ;
         endcase
      end
   end

   wbss_match u_match (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .status    (status)
   );

   wbss_score u_score (
      .status      (status),
      .min_length  (min_length_ff),
      .score_limit (score_limit_ff),
      .score       (score)
   );

   wbss_out_buf u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .push             (accept && req_last_byte),
      .push_score       (score),
      .full             (full),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_threat_score (rsp_threat_score)
   );

endmodule

### tb/weighted_byte_signature_scanner_top_tb.sv
`timescale 1ns / 100ps
// Testbench for weighted_byte_signature_scanner_top: sends byte buffers with planted
// signatures under random idling and checks each threat score against a predictor.
// Depends on wbss_pkg and the scanner RTL.
module weighted_byte_signature_scanner_top_tb;
   import wbss_pkg::*;

   localparam int ITEM_TARGET = 1900;
   localparam int MAX_SHOWN   = 10;
   localparam int SIG_COUNT   = 4;
   localparam int SIG_MAX_LEN = 8;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [SCORE_W-1:0] score_type;
   typedef byte_type byte_q_type[$];

   // signatures in buffer order
   localparam int SIG_BYTES [SIG_COUNT] = '{8, 2, 2, 5};
   localparam int SIG_SCORE [SIG_COUNT] = '{8, 7, 5, 6};
   localparam byte_type SIG_PATTERN [SIG_COUNT][SIG_MAX_LEN] = '{
      '{8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90},
      '{8'hCD, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h60, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hEB, 8'h1F, 8'h5E, 8'h89, 8'h76, 8'h00, 8'h00, 8'h00}
   };
   localparam byte_type HOT_BYTES [10] = '{8'h90, 8'hCD, 8'h80, 8'h60, 8'h61,
                                           8'hEB, 8'h1F, 8'h5E, 8'h89, 8'h76};

   class score_tracker_type;
      byte_type             history [SIG_MAX_LEN-1];
      byte_type             length_seen;
      logic [SIG_COUNT-1:0] hits;
      byte_type             min_length;
      score_type            score_limit;
      score_type            expected_scores [$];
      int                   failures;

      function new();
         min_length  = 8'd8;
         score_limit = 7'd100;
         failures    = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         foreach (history[k]) history[k] = '0;
         length_seen = '0;
         hits        = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_MIN_LENGTH:  min_length  = data;
            CSR_SCORE_LIMIT: score_limit = data[SCORE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_byte(byte_type data, logic last);
         int       count;
         int       total;
         bit       hit;
         byte_type seen_byte;
         count = (length_seen < 8'd255) ? length_seen + 1 : 255;
         for (int s = 0; s < SIG_COUNT; s++) begin
            if (count >= SIG_BYTES[s]) begin
               hit = 1'b1;
               for (int k = 0; k < SIG_BYTES[s]; k++) begin
                  if (k == 0) seen_byte = data;
                  else seen_byte = history[k-1];
                  if (seen_byte != SIG_PATTERN[s][SIG_BYTES[s]-1-k]) hit = 1'b0;
               end
               if (hit) hits[s] = 1'b1;
            end
         end
         for (int k = SIG_MAX_LEN - 2; k > 0; k--) history[k] = history[k-1];
         history[0]  = data;
         length_seen = count[BYTE_W-1:0];
         if (last) begin
            total = 0;
            if (count >= min_length) begin
               for (int s = 0; s < SIG_COUNT; s++)
                  if (hits[s]) total += SIG_SCORE[s];
               if (total > score_limit) total = score_limit;
            end
            expected_scores.push_back(score_type'(total));
            clear_scan();
         end
      endfunction

      function void check_score(score_type got);
         score_type want;
         if (expected_scores.size() == 0) begin
            failures++;
            if (failures <= MAX_SHOWN) $display("unexpected score transfer: %0d", got);
         end else begin
            want = expected_scores.pop_front();
            if (got !== want) begin
               failures++;
               if (failures <= MAX_SHOWN)
                  $display("score mismatch: expected %0d, got %0d", want, got);
            end
         end
      endfunction

      function void wrap_up();
         if (expected_scores.size() != 0) begin
            failures++;
            if (failures <= MAX_SHOWN)
               $display("%0d expected scores never arrived", expected_scores.size());
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   byte_type              req_data_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_stall = 1'b0;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   score_type             rsp_threat_score;

   score_tracker_type tracker = new();
   bit                send_gaps = 1'b0;
   bit                recv_stalls = 1'b0;
   int                items_sent = 0;
   int                stall_left = 0;

   weighted_byte_signature_scanner_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_threat_score (rsp_threat_score),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left == 0 && recv_stalls) stall_left = idle_len();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker.check_score(rsp_threat_score);
         if (req_valid && !req_stall) tracker.note_byte(req_data_byte, req_last_byte);
      end
   end

   function automatic byte_type random_byte();
      if ($urandom_range(0, 1)) return HOT_BYTES[$urandom_range(0, 9)];
      return byte_type'($urandom);
   endfunction

   function automatic byte_q_type make_buffer(int length);
      byte_q_type bytes_q;
      int         s;
      int         pos;
      int         tail;
      for (int i = 0; i < length; i++) bytes_q.push_back(random_byte());
      repeat ($urandom_range(0, 3)) begin
         s = $urandom_range(0, SIG_COUNT - 1);
         if (SIG_BYTES[s] <= length) begin
            pos = $urandom_range(0, length - SIG_BYTES[s]);
            for (int k = 0; k < SIG_BYTES[s]; k++) bytes_q[pos+k] = SIG_PATTERN[s][k];
         end
      end
      // signature cut off by the start of the buffer
      if ($urandom_range(0, 4) == 0) begin
         s    = $urandom_range(0, SIG_COUNT - 1);
         tail = $urandom_range(1, SIG_BYTES[s] - 1);
         if (tail <= length)
            for (int k = 0; k < tail; k++)
               bytes_q[k] = SIG_PATTERN[s][SIG_BYTES[s]-tail+k];
      end
      return bytes_q;
   endfunction

   function automatic int pick_length(int min_length);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return $urandom_range(256, 300);
      if (r < 15) return (min_length < 2) ? 1 : min_length + $urandom_range(0, 2) - 1;
      return $urandom_range(1, 24);
   endfunction

   task automatic send_byte(byte_type data, logic last);
      int gap;
      gap = send_gaps ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_buffer(byte_q_type bytes_q);
      foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_scores.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(byte_type min_length, logic [CSR_DATA_W-1:0] limit_word);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MIN_LENGTH;
      csr_wdata    <= min_length;
      @(posedge clock);
      tracker.write_reg(CSR_MIN_LENGTH, min_length);
      csr_index <= CSR_SCORE_LIMIT;
      csr_wdata <= limit_word;
      @(posedge clock);
      tracker.write_reg(CSR_SCORE_LIMIT, limit_word);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      byte_q_type bytes_q;
      int         min_length;
      int         limit;
      int         phase;
      int         length;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset config: all four signatures, then a short buffer
      bytes_q = {8'hCD, 8'h80, 8'h60, 8'h61, 8'hEB, 8'h1F, 8'h5E, 8'h89, 8'h76,
                 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'hFF, 8'h00};
      send_buffer(bytes_q);
      bytes_q = {8'h00};
      send_buffer(bytes_q);
      drain();
      // min length below range, limit written with bit 7 set
      set_config(8'd1, 8'hFF);
      bytes_q = {8'hCD};
      send_buffer(bytes_q);
      bytes_q = {8'h80};
      send_buffer(bytes_q);
      bytes_q = {8'h60, 8'h61};
      send_buffer(bytes_q);
      drain();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 4))
            0: min_length = 8;
            1: min_length = 255;
            2: min_length = $urandom_range(0, 7);
            3: min_length = $urandom_range(8, 30);
            default: min_length = $urandom_range(0, 255);
         endcase
         case ($urandom_range(0, 4))
            0: limit = 0;
            1: limit = 100;
            2: limit = 127;
            3: limit = $urandom_range(1, 30);
            default: limit = $urandom_range(0, 127);
         endcase
         if (phase == 0) begin
            min_length = 255;
            limit      = 127;
         end
         set_config(byte_type'(min_length), {1'($urandom_range(0, 1)), 7'(limit)});
         send_gaps   = ($urandom_range(0, 3) != 0);
         recv_stalls = ($urandom_range(0, 3) != 0);
         for (int b = $urandom_range(4, 12); b > 0; b--) begin
            length = (phase == 0 && b == 1) ? 300 : pick_length(min_length);
            send_buffer(make_buffer(length));
         end
         drain();
         phase++;
      end

      tracker.wrap_up();
      if (tracker.failures == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
sv/wbss_pkg.sv
sv/wbss_match.sv
sv/wbss_score.sv
sv/wbss_out_buf.sv
sv/weighted_byte_signature_scanner_top.sv
tb/weighted_byte_signature_scanner_top_tb.sv
